// File: src/tdap_pkg.sv
// Shared types and constants for the templated dotted address packer.
package tdap_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_NUL   = 8'd0;

    localparam logic CFG_SEG_COUNT  = 1'b0;
    localparam logic CFG_SEG_WIDTHS = 1'b1;

    localparam logic [3:0]  RST_SEG_COUNT  = 4'd4;
    localparam logic [47:0] RST_SEG_WIDTHS = 48'd2130440;

    localparam logic [32:0] VALUE_CAP = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_PRE,
        PH_SIGN,
        PH_NUM,
        PH_REST,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        LZ_NONE,
        LZ_ZERO,
        LZ_OTHER
    } t_lone;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       take;
        logic       first;
        logic       last;
        logic       blank;
        logic       digit;
        logic       dot;
        logic       plus;
        logic       minus;
        logic       zero_char;
        logic [3:0] digit_val;
    } t_entry;

endpackage

// File: src/tdap_front.sv
// Front end: accepts character beats, applies the buffer limit and classifies them.
module tdap_front #(
    parameter int MAX_STRING_LEN = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    input  logic            i_q_not_full,
    output logic            o_ready,
    output logic            o_push,
    output tdap_pkg::t_entry o_entry
);

    localparam int CW = $clog2(MAX_STRING_LEN);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_STRING_LEN - 1);

    logic [CW-1:0] r_char_count;
    logic [CW-1:0] n_char_count;
    logic          room;

    assign o_ready = i_q_not_full;
    assign o_push  = i_valid && i_q_not_full;
    assign room    = (r_char_count < LIMIT);

    always_comb begin
        o_entry.take      = room && (i_char != tdap_pkg::CH_NUL);
        o_entry.first     = (r_char_count == '0);
        o_entry.last      = i_last;
        o_entry.blank     = (i_char == tdap_pkg::CH_SPACE) ||
                            ((i_char >= tdap_pkg::CH_TAB) && (i_char <= tdap_pkg::CH_CR));
        o_entry.digit     = (i_char >= tdap_pkg::CH_ZERO) && (i_char <= tdap_pkg::CH_NINE);
        o_entry.dot       = (i_char == tdap_pkg::CH_DOT);
        o_entry.plus      = (i_char == tdap_pkg::CH_PLUS);
        o_entry.minus     = (i_char == tdap_pkg::CH_MINUS);
        o_entry.zero_char = (i_char == tdap_pkg::CH_ZERO);
        o_entry.digit_val = i_char[3:0];
    end

    // A zero byte ends the text, so the counter jumps to the limit.
    always_comb begin
        n_char_count = r_char_count;
        if (i_last) begin
            n_char_count = '0;
        end else if (room) begin
            n_char_count = (i_char == tdap_pkg::CH_NUL) ? LIMIT : r_char_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
        end else if (o_push) begin
            r_char_count <= n_char_count;
        end
    end

endmodule

// File: src/tdap_queue.sv
// Short queue of classified characters between the front and the back.
module tdap_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tdap_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_not_full,
    output logic             o_not_empty,
    output tdap_pkg::t_entry o_head
);

    localparam int DEPTH = tdap_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tdap_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_not_full  = (r_count != CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/tdap_back.sv
// Back end: scans segments, packs them by the template and registers the result beat.
module tdap_back #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [3:0]       i_seg_count,
    input  logic [47:0]      i_seg_widths,
    input  logic             i_q_valid,
    input  tdap_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_address,
    output logic             o_status
);

    logic [3:0]       r_left,    n_left;
    logic [32:0]      r_value,   n_value;
    logic [31:0]      r_packed,  n_packed;
    tdap_pkg::t_phase r_phase,   n_phase;
    logic             r_neg,     n_neg;
    logic             r_nonempty, n_nonempty;
    logic             r_err,     n_err;
    logic             r_bpend,   n_bpend;
    tdap_pkg::t_lone  r_lone,    n_lone;

    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_addr,  n_out_addr;
    logic             r_out_status, n_out_status;

    logic [3:0]  live;
    logic [36:0] acc;
    logic [32:0] acc_sat;
    logic        do_close;
    logic        close_ne;
    logic        final_close;
    logic [2:0]  idx;
    logic [8:0]  start;
    logic [5:0]  width;
    logic        too_big;
    logic        step;

    assign live = (i_seg_count > 4'(MAX_SEGMENTS)) ? 4'(MAX_SEGMENTS) : i_seg_count;

    always_comb begin
        acc = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) + {33'b0, i_entry.digit_val};
        acc_sat = (acc > {4'b0, tdap_pkg::VALUE_CAP}) ? tdap_pkg::VALUE_CAP : acc[32:0];
    end

    // Next string state.
    always_comb begin
        n_left      = i_entry.first ? live : r_left;
        n_value     = r_value;
        n_packed    = r_packed;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_nonempty  = r_nonempty;
        n_err       = r_err;
        n_bpend     = r_bpend;
        n_lone      = r_lone;
        do_close    = 1'b0;
        close_ne    = 1'b0;
        final_close = 1'b0;
        idx         = '0;
        start       = '0;
        width       = '0;
        too_big     = 1'b0;

        if (i_entry.take) begin
            if (!i_entry.blank) begin
                n_lone = ((r_lone == tdap_pkg::LZ_NONE) && i_entry.zero_char) ?
                         tdap_pkg::LZ_ZERO : tdap_pkg::LZ_OTHER;
            end
            if (!r_err) begin
                if (r_phase == tdap_pkg::PH_TAIL) begin
                    if (!i_entry.blank) begin
                        n_err = 1'b1;
                    end
                end else if (r_phase == tdap_pkg::PH_LEAD && i_entry.blank) begin
                    n_phase = r_phase;
                end else if (r_phase == tdap_pkg::PH_LEAD && n_left == '0) begin
                    n_err = 1'b1;
                end else begin
                    if (r_phase == tdap_pkg::PH_LEAD) begin
                        n_phase = tdap_pkg::PH_PRE;
                    end
                    if (i_entry.dot) begin
                        do_close = 1'b1;
                        close_ne = r_nonempty || r_bpend;
                    end else if (i_entry.blank) begin
                        n_bpend = 1'b1;
                        if (n_phase == tdap_pkg::PH_SIGN || n_phase == tdap_pkg::PH_NUM) begin
                            n_phase = tdap_pkg::PH_REST;
                        end
                    end else begin
                        n_nonempty = 1'b1;
                        case (n_phase)
                            tdap_pkg::PH_PRE: begin
                                if (i_entry.plus) begin
                                    n_phase = tdap_pkg::PH_SIGN;
                                end else if (i_entry.minus) begin
                                    n_neg   = 1'b1;
                                    n_phase = tdap_pkg::PH_SIGN;
                                end else if (i_entry.digit) begin
                                    n_value = {29'b0, i_entry.digit_val};
                                    n_phase = tdap_pkg::PH_NUM;
                                end else begin
                                    n_phase = tdap_pkg::PH_REST;
                                end
                            end
                            tdap_pkg::PH_SIGN: begin
                                if (i_entry.digit) begin
                                    n_value = {29'b0, i_entry.digit_val};
                                    n_phase = tdap_pkg::PH_NUM;
                                end else begin
                                    n_phase = tdap_pkg::PH_REST;
                                end
                            end
                            tdap_pkg::PH_NUM: begin
                                if (i_entry.digit) begin
                                    n_value = acc_sat;
                                end else begin
                                    n_phase = tdap_pkg::PH_REST;
                                end
                            end
                            default: begin
                                n_phase = n_phase;
                            end
                        endcase
                    end
                end
            end
        end

        // Closing the string shares the segment closer with the dot path,
        // since a dot beat never needs a second close.
        if (i_entry.last && n_lone != tdap_pkg::LZ_ZERO && !n_err && !do_close) begin
            if (n_phase == tdap_pkg::PH_LEAD) begin
                if (n_left != '0) begin
                    n_err = 1'b1;
                end
            end else if (n_phase != tdap_pkg::PH_TAIL) begin
                do_close    = 1'b1;
                close_ne    = n_nonempty;
                final_close = 1'b1;
            end
        end

        if (do_close) begin
            if (n_left == '0) begin
                n_err = 1'b1;
            end else begin
                idx = 3'(n_left - 4'd1);
                for (int j = 0; j < 8; j++) begin
                    if (3'(j) < idx) begin
                        start = start + {3'b0, i_seg_widths[6*j +: 6]};
                    end
                    if (3'(j) == idx) begin
                        width = i_seg_widths[6*j +: 6];
                    end
                end
                too_big = (width >= 6'd32) ? n_value[32] : ((n_value >> width) != '0);
                if (!close_ne || (n_neg && n_value != '0) || too_big) begin
                    n_err = 1'b1;
                end else if (start[8:5] == '0) begin
                    n_packed = n_packed + (n_value[31:0] << start[4:0]);
                end
                n_left     = n_left - 4'd1;
                n_value    = '0;
                n_neg      = 1'b0;
                n_nonempty = 1'b0;
                n_bpend    = 1'b0;
                if (i_entry.dot && !n_err) begin
                    n_phase = (n_left == '0) ? tdap_pkg::PH_TAIL : tdap_pkg::PH_PRE;
                end
            end
            if (final_close && n_left != '0) begin
                n_err = 1'b1;
            end
        end

        // A dot as the last byte leaves an empty segment unless the template is full.
        if (i_entry.last && i_entry.dot && do_close && n_phase == tdap_pkg::PH_PRE) begin
            n_err = 1'b1;
        end
    end

    // Handshake and result beat.
    always_comb begin
        o_pop        = i_q_valid && (!i_entry.last || !r_out_valid || i_ready);
        n_out_valid  = (o_pop && i_entry.last) || (r_out_valid && !i_ready);
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        if (o_pop && i_entry.last) begin
            if (n_lone == tdap_pkg::LZ_ZERO) begin
                n_out_addr   = '0;
                n_out_status = 1'b0;
            end else begin
                n_out_addr   = n_err ? 32'd0 : n_packed;
                n_out_status = n_err;
            end
        end
    end

    assign step = o_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= live;
            r_value    <= '0;
            r_packed   <= '0;
            r_phase    <= tdap_pkg::PH_LEAD;
            r_neg      <= 1'b0;
            r_nonempty <= 1'b0;
            r_err      <= 1'b0;
            r_bpend    <= 1'b0;
            r_lone     <= tdap_pkg::LZ_NONE;
        end else if (step && i_entry.last) begin
            r_left     <= live;
            r_value    <= '0;
            r_packed   <= '0;
            r_phase    <= tdap_pkg::PH_LEAD;
            r_neg      <= 1'b0;
            r_nonempty <= 1'b0;
            r_err      <= 1'b0;
            r_bpend    <= 1'b0;
            r_lone     <= tdap_pkg::LZ_NONE;
        end else if (step) begin
            r_left     <= n_left;
            r_value    <= n_value;
            r_packed   <= n_packed;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_nonempty <= n_nonempty;
            r_err      <= n_err;
            r_bpend    <= n_bpend;
            r_lone     <= n_lone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_valid   = r_out_valid;
    assign o_address = r_out_addr;
    assign o_status  = r_out_status;

endmodule

// File: src/templated_dotted_address_pack_top.sv
// Top level of the templated dotted address packer: template registers and the two halves.
//
//  Channel  Dir  Handshake                     Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata[7:0] char_code, tlast end_of_string
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata[31:0] address, tuser[0] status
//  cfg      in   i_cfg_we                      i_cfg_index, i_cfg_wdata[47:0]
//
// One character beat is taken every cycle while the four-entry character queue has room.
// A string's result beat is registered when its last character beat leaves the queue head,
// which waits while an earlier result beat is stalled; otherwise the back end retires one
// character per cycle while the queue holds characters.
// Reset is synchronous and restores the default template of four segments.
// A stalled result beat holds in the output register while characters keep filling the queue.
module templated_dotted_address_pack_top #(
    parameter int MAX_SEGMENTS   = 8,
    parameter int MAX_STRING_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] address
    output logic        m_axis_tuser,   // [0] status
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_wdata
);

    logic [3:0]       r_seg_count;
    logic [47:0]      r_seg_widths;
    logic             q_not_full;
    logic             q_not_empty;
    logic             push;
    logic             pop;
    tdap_pkg::t_entry front_entry;
    tdap_pkg::t_entry head_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count  <= tdap_pkg::RST_SEG_COUNT;
            r_seg_widths <= tdap_pkg::RST_SEG_WIDTHS;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tdap_pkg::CFG_SEG_COUNT) begin
                r_seg_count <= i_cfg_wdata[3:0];
            end else if (i_cfg_index == tdap_pkg::CFG_SEG_WIDTHS) begin
                r_seg_widths <= i_cfg_wdata;
            end
        end
    end

    tdap_front #(
        .MAX_STRING_LEN(MAX_STRING_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_char      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_q_not_full(q_not_full),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    tdap_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (front_entry),
        .i_pop      (pop),
        .o_not_full (q_not_full),
        .o_not_empty(q_not_empty),
        .o_head     (head_entry)
    );

    tdap_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_count (r_seg_count),
        .i_seg_widths(r_seg_widths),
        .i_q_valid   (q_not_empty),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_address   (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule
